### hdl/pfc_pkg.sv
// types and constants shared by the palette foreground classifier
package pfc_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_ANALYZE = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_WAIT,
    ST_THR_MUL,
    ST_THR_SET,
    ST_DONE
  } state_e;

  // entry fields, each 8 bits
  localparam int unsigned FieldW = 8;
  localparam int unsigned EntryW = 4 * FieldW;
  // weighted luminosity 0..765, threshold 0..688
  localparam int unsigned LumaW  = 10;
  localparam int unsigned ProdW  = 18;
  localparam int unsigned Thr9W  = 13;
  // floor(x / 10) as (x * 6554) >> 16, exact for x below 7000
  localparam logic [15:0] RecipTen = 16'd6554;
  localparam logic [7:0]  AlphaMax = 8'd255;

  typedef struct packed {
    logic capture;
    logic wr_en;
    logic clr;
    logic rd_issue;
    logic rd_from_cnt;
    logic cnt_clr;
    logic best_clr;
    logic vis_set;
    logic thr_mul;
    logic thr_set;
    logic out_load;
  } pfc_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  wr_ok;
    logic  q_ok;
    logic  scan_last;
    logic  wl_done;
    logic  out_free;
  } pfc_sts_t;

endpackage

### hdl/pfc_ram.sv
// generic single write port ram with registered read
module pfc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pfc_dp.sv
// datapath: palette store, weighted luminosity pipeline, threshold and output word
module pfc_dp import pfc_pkg::*; #(
  parameter int unsigned PaletteDepth = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfc_cmd_t         cmd_i,
  output pfc_sts_t         sts_o,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       entry_index_i,
  input  logic [7:0]       luma_i,
  input  logic [7:0]       chroma_red_i,
  input  logic [7:0]       chroma_blue_i,
  input  logic [7:0]       opacity_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             visible_o,
  output logic [LumaW-1:0] threshold_now_o
);

  localparam int unsigned AddrW  = $clog2(PaletteDepth);
  localparam logic [8:0]  DepthW = 9'(PaletteDepth);

  // captured input word
  mode_e       mode_q;
  logic [7:0]  idx_q;
  logic [7:0]  y_q, cr_q, cb_q, a_q;

  logic [PaletteDepth-1:0] valid_q;
  logic [7:0]       highest_q;
  logic [AddrW-1:0] cnt_q;
  logic [AddrW-1:0] rd_addr;
  logic [EntryW-1:0] rdata;

  logic             p1_vld_q, p1_last_q, p1_ok_q;
  logic             p2_vld_q, p2_last_q;
  logic             p3_vld_q, p3_last_q;
  logic             p4_vld_q, p4_last_q;
  logic [ProdW-1:0] prod_q, prod2_q;
  logic [LumaW-1:0] q0_q, wl_q;

  logic [LumaW-1:0] sum_rgb;
  logic [25:0]      q0_full;
  logic [ProdW-1:0] q0_x255;
  logic [ProdW-1:0] rem;

  logic [LumaW-1:0] best_q;
  logic [Thr9W-1:0] thr9_q;
  logic [28:0]      thr_full;
  logic [LumaW-1:0] thr_q, thr_d;
  logic             vis_q;

  logic             out_vld_q, out_vis_q;
  logic [LumaW-1:0] out_thr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      idx_q  <= entry_index_i;
      y_q    <= luma_i;
      cr_q   <= chroma_red_i;
      cb_q   <= chroma_blue_i;
      a_q    <= opacity_i;
    end
  end

  assign rd_addr = cmd_i.rd_from_cnt ? cnt_q : idx_q[AddrW-1:0];

  pfc_ram #(
    .Width (EntryW),
    .Depth (PaletteDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i ({y_q, cr_q, cb_q, a_q}),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // entry valid bits, highest index and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      highest_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.clr) begin
        valid_q   <= '0;
        highest_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[idx_q[AddrW-1:0]] <= 1'b1;
        if (idx_q > highest_q) begin
          highest_q <= idx_q;
        end
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_issue && cmd_i.rd_from_cnt) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // weighted luminosity pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p1_last_q <= 1'b0;
      p1_ok_q   <= 1'b0;
      p2_vld_q  <= 1'b0;
      p2_last_q <= 1'b0;
      p3_vld_q  <= 1'b0;
      p3_last_q <= 1'b0;
      p4_vld_q  <= 1'b0;
      p4_last_q <= 1'b0;
    end else begin
      p1_vld_q  <= cmd_i.rd_issue;
      p1_last_q <= cmd_i.rd_issue &&
                   (!cmd_i.rd_from_cnt || (cnt_q == highest_q[AddrW-1:0]));
      p1_ok_q   <= valid_q[rd_addr];
      p2_vld_q  <= p1_vld_q;
      p2_last_q <= p1_last_q;
      p3_vld_q  <= p2_vld_q;
      p3_last_q <= p2_last_q;
      p4_vld_q  <= p3_vld_q;
      p4_last_q <= p3_last_q;
    end
  end

  // sum times alpha, then divide by 255 via 257/65536 with one correction
  assign sum_rgb = LumaW'(rdata[31:24]) + LumaW'(rdata[23:16]) + LumaW'(rdata[15:8]);
  assign q0_full = 26'(prod_q) + {prod_q, 8'b0};
  assign q0_x255 = {q0_q, 8'b0} - ProdW'(q0_q);
  assign rem     = prod2_q - q0_x255;

  always_ff @(posedge clk_i) begin
    prod_q  <= p1_ok_q ? ProdW'(sum_rgb * rdata[7:0]) : '0;
    q0_q    <= q0_full[25:16];
    prod2_q <= prod_q;
    wl_q    <= (rem >= ProdW'(AlphaMax)) ? q0_q + 1'b1 : q0_q;
  end

  // running maximum and threshold
  assign thr_full = thr9_q * RecipTen;

  always_comb begin
    thr_d = thr_q;
    if (cmd_i.clr) begin
      thr_d = '0;
    end else if (cmd_i.thr_set) begin
      thr_d = thr_full[25:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      thr9_q <= '0;
      thr_q  <= '0;
      vis_q  <= 1'b0;
    end else begin
      if (cmd_i.best_clr) begin
        best_q <= '0;
      end else if (p4_vld_q && (wl_q > best_q)) begin
        best_q <= wl_q;
      end
      if (cmd_i.thr_mul) begin
        thr9_q <= {best_q, 3'b0} + Thr9W'(best_q);
      end
      thr_q <= thr_d;
      if (cmd_i.capture) begin
        vis_q <= 1'b0;
      end else if (cmd_i.vis_set) begin
        vis_q <= wl_q > thr_q;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_vis_q <= vis_q;
      out_thr_q <= thr_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign visible_o       = out_vis_q;
  assign threshold_now_o = out_thr_q;

  assign sts_o.mode      = mode_q;
  assign sts_o.wr_ok     = {1'b0, idx_q} < DepthW;
  assign sts_o.q_ok      = idx_q <= highest_q;
  assign sts_o.scan_last = cnt_q == highest_q[AddrW-1:0];
  assign sts_o.wl_done   = p4_vld_q && p4_last_q;
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

endmodule

### hdl/pfc_ctrl.sv
// controller state machine sequencing write, analyze, query and clear
module pfc_ctrl import pfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pfc_sts_t sts_i,
  output pfc_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.mode)
          MODE_ANALYZE: state_d = ST_SCAN;
          MODE_QUERY: begin
            if (sts_i.q_ok) state_d = ST_WAIT;
            else            state_d = sts_i.out_free ? ST_IDLE : ST_DONE;
          end
          default: state_d = sts_i.out_free ? ST_IDLE : ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.wl_done) begin
          state_d = (sts_i.mode == MODE_QUERY) ? ST_DONE : ST_THR_MUL;
        end
      end
      ST_THR_MUL: state_d = ST_THR_SET;
      ST_THR_SET: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      ST_DISPATCH: begin
        case (sts_i.mode)
          MODE_WRITE: begin
            cmd_o.wr_en    = sts_i.wr_ok;
            cmd_o.out_load = sts_i.out_free;
          end
          MODE_ANALYZE: begin
            cmd_o.best_clr = 1'b1;
            cmd_o.cnt_clr  = 1'b1;
          end
          MODE_QUERY: begin
            cmd_o.rd_issue = sts_i.q_ok;
            cmd_o.out_load = !sts_i.q_ok && sts_i.out_free;
          end
          MODE_CLEAR: begin
            cmd_o.clr      = 1'b1;
            cmd_o.out_load = sts_i.out_free;
          end
          default: cmd_o = '0;
        endcase
      end
      ST_SCAN: begin
        cmd_o.rd_issue    = 1'b1;
        cmd_o.rd_from_cnt = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.vis_set = sts_i.wl_done && (sts_i.mode == MODE_QUERY);
      end
      ST_THR_MUL: cmd_o.thr_mul = 1'b1;
      ST_THR_SET: cmd_o.thr_set = 1'b1;
      ST_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### hdl/palette_foreground_classifier.sv
// top level of the palette foreground classifier
//
// channel  direction  handshake                  word
// in       input      in_valid_i / in_stall_o    mode, entry_index, luma, chroma_red,
//                                                chroma_blue, opacity
// out      output     out_valid_o / out_stall_i  visible, threshold_now
//
// write, clear and out-of-range query finish in the dispatch state; a query in range waits
// on the 4-stage read, multiply and divide-by-255 pipeline behind the store.
// analyze reads entries 0 up to the highest index, one store read a cycle, then waits on
// the pipeline and the two-step times-0.9 threshold.
// reset clears valid bits of every entry at once, so no clearing pass is needed.
// a stalled output word holds; the next input word is taken meanwhile and waits at the end.
module palette_foreground_classifier import pfc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] luma_i,
  input  logic [7:0] chroma_red_i,
  input  logic [7:0] chroma_blue_i,
  input  logic [7:0] opacity_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       visible_o,
  output logic [9:0] threshold_now_o
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfc_dp #(
    .PaletteDepth (PALETTE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .entry_index_i   (entry_index_i),
    .luma_i          (luma_i),
    .chroma_red_i    (chroma_red_i),
    .chroma_blue_i   (chroma_blue_i),
    .opacity_i       (opacity_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .visible_o       (visible_o),
    .threshold_now_o (threshold_now_o)
  );

endmodule
